// File: hdl/voice_channel_allocator_top_macros.svh
// ----------------------------------------------------------------------------
// Voice channel allocator assertion macros
// Shared concurrent assertion forms, sampled on the rising clock edge and
// disabled while reset is low.
// ----------------------------------------------------------------------------
`ifndef VOICE_CHANNEL_ALLOCATOR_TOP_MACROS_SVH
`define VOICE_CHANNEL_ALLOCATOR_TOP_MACROS_SVH

// Same-cycle implication
`define VCA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define VCA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/vca_pkg.sv
// ----------------------------------------------------------------------------
// Voice channel allocator package
// Operation and status codes and fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package vca_pkg;

    localparam int AGE_W = 32;
    localparam int ELAPSED_W = 16;
    localparam int CHAN_NUM_W = 6;
    localparam int CHOSEN_W = 5;

    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_ALLOC   = 2'd1;
    localparam logic [1:0] OP_RELEASE = 2'd2;

    localparam logic [1:0] ST_TICK_DONE = 2'd0;
    localparam logic [1:0] ST_ALLOCATED = 2'd1;
    localparam logic [1:0] ST_RELEASED  = 2'd2;
    localparam logic [1:0] ST_BAD_CHAN  = 2'd3;

endpackage

`default_nettype wire

// File: hdl/vca_age_ram.sv
// ----------------------------------------------------------------------------
// Channel age memory
// One write port and one read port; read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module vca_age_ram
    import vca_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [AGE_W-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [AGE_W-1:0] o_rdata
);

    logic [AGE_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: hdl/voice_channel_allocator_top.sv
// ----------------------------------------------------------------------------
// Voice channel allocator
// Tracks free flags and ages of playback channels; allocates the lowest free
// channel, or steals the oldest one when all are busy.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake                 Payload
//  s_axis    in   tvalid / tready           tuser: operation; tdata: channel,
//                                           elapsed_ms, playing_mask
//  m_axis    out  tvalid / tready           tuser: status; tdata: chosen_channel
//
//  Tick: walks the age memory, one entry a cycle.
//  Allocate: takes the lowest free channel directly, else scans for the oldest.
//  Release and unused codes: answered without a walk. One transaction is worked at a time.
//  Reset: ages clear through per-entry valid bits at once; no clearing pass.
//  A stalled output holds in its register; the next input is still taken.
// ----------------------------------------------------------------------------
`default_nettype none

module voice_channel_allocator_top
    import vca_pkg::*;
#(
    parameter int NUM_CHANNELS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // [5:0] channel_number, [21:6] elapsed_ms, [53:22] playing_mask, [55:54] zero
    input  wire logic [55:0] i_s_axis_tdata,
    // [1:0] operation
    input  wire logic [1:0]  i_s_axis_tuser,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // [4:0] chosen_channel, [7:5] zero
    output logic [7:0]       o_m_axis_tdata,
    // [1:0] status
    output logic [1:0]       o_m_axis_tuser
);

    `include "voice_channel_allocator_top_macros.svh"

    localparam int IW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CW = $clog2(NUM_CHANNELS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } t_state;

    t_state                r_state;
    logic [1:0]            r_op;
    logic [ELAPSED_W-1:0]  r_elapsed;
    logic [CW-1:0]         r_cnt;
    logic                  r_pipe_vld;
    logic [IW-1:0]         r_pipe_idx;
    logic                  r_pipe_av;
    logic [AGE_W-1:0]      r_best;
    logic [IW-1:0]         r_pick;
    logic [1:0]            r_res_status;
    logic [NUM_CHANNELS-1:0] r_free;
    logic [NUM_CHANNELS-1:0] r_age_vld;
    logic                  r_out_valid;
    logic [1:0]            r_out_status;
    logic [CHOSEN_W-1:0]   r_out_chan;

    logic [1:0]            in_op;
    logic [CHAN_NUM_W-1:0] in_chan;
    logic [ELAPSED_W-1:0]  in_elapsed;
    logic [31:0]           in_mask;
    logic                  in_acc;
    logic                  chan_ok;
    logic                  any_free;
    logic [IW-1:0]         free_idx;
    logic                  cnt_live;
    logic [IW-1:0]         rd_idx;
    logic [AGE_W-1:0]      rd_data;
    logic [AGE_W-1:0]      age_q;
    logic [AGE_W:0]        age_sum;
    logic [AGE_W-1:0]      age_sat;
    logic                  better;
    logic [IW-1:0]         pick_nx;
    logic                  scan_last;
    logic                  mem_we;
    logic                  load_out;

    assign in_op      = i_s_axis_tuser;
    assign in_chan    = i_s_axis_tdata[5:0];
    assign in_elapsed = i_s_axis_tdata[21:6];
    assign in_mask    = i_s_axis_tdata[53:22];

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign chan_ok = ({1'b0, in_chan} < 7'(NUM_CHANNELS));

    // Lowest-numbered free channel
    always_comb begin
        any_free = 1'b0;
        free_idx = '0;
        for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
            if (r_free[i]) begin
                any_free = 1'b1;
                free_idx = IW'(i);
            end
        end
    end

    assign cnt_live = (r_cnt < CW'(NUM_CHANNELS));
    assign rd_idx   = cnt_live ? r_cnt[IW-1:0] : '0;

    // Entry never written since reset or since its last allocation reads as zero age
    assign age_q   = r_pipe_av ? rd_data : '0;
    assign age_sum = {1'b0, age_q} + (AGE_W + 1)'(r_elapsed);
    assign age_sat = age_sum[AGE_W] ? '1 : age_sum[AGE_W-1:0];

    assign better    = (r_pipe_idx == '0) || (age_q > r_best);
    assign pick_nx   = better ? r_pipe_idx : r_pick;
    assign scan_last = r_pipe_vld && (r_pipe_idx == IW'(NUM_CHANNELS - 1));
    // Only playing channels age; the free flags already hold the inverted mask
    assign mem_we    = (r_state == S_RUN) && r_pipe_vld && (r_op == OP_TICK) &&
                       !r_free[r_pipe_idx];
    assign load_out  = (r_state == S_DONE) && (!r_out_valid || i_m_axis_tready);

    vca_age_ram #(
        .DEPTH (NUM_CHANNELS),
        .AW    (IW)
    ) u_age_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_pipe_idx),
        .i_wdata (age_sat),
        .i_raddr (rd_idx),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_pipe_vld  <= 1'b0;
            r_cnt       <= '0;
            r_free      <= '1;
            r_age_vld   <= '0;
        end else begin
            r_pipe_vld <= 1'b0;
            if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_op      <= in_op;
                        r_elapsed <= in_elapsed;
                        r_cnt     <= '0;
                        r_pick    <= '0;
                        case (in_op)
                            OP_TICK: begin
                                for (int i = 0; i < NUM_CHANNELS; i++) begin
                                    r_free[i] <= ~in_mask[i];
                                end
                                r_res_status <= ST_TICK_DONE;
                                r_state      <= S_RUN;
                            end
                            OP_ALLOC: begin
                                r_res_status <= ST_ALLOCATED;
                                if (any_free) begin
                                    r_pick              <= free_idx;
                                    r_age_vld[free_idx] <= 1'b0;
                                    r_state             <= S_DONE;
                                end else begin
                                    r_state <= S_RUN;
                                end
                            end
                            OP_RELEASE: begin
                                if (chan_ok) begin
                                    r_free[in_chan[IW-1:0]] <= 1'b1;
                                    r_res_status            <= ST_RELEASED;
                                end else begin
                                    r_res_status <= ST_BAD_CHAN;
                                end
                                r_state <= S_DONE;
                            end
                            default: begin
                                r_res_status <= ST_BAD_CHAN;
                                r_state      <= S_DONE;
                            end
                        endcase
                    end
                end
                S_RUN: begin
                    // Issue one read a cycle; handle its data in the cycle after
                    if (cnt_live) begin
                        r_cnt      <= r_cnt + CW'(1);
                        r_pipe_vld <= 1'b1;
                        r_pipe_idx <= rd_idx;
                        r_pipe_av  <= r_age_vld[rd_idx];
                    end
                    if (r_pipe_vld) begin
                        if (r_op == OP_TICK) begin
                            // Idle channels keep their age
                            if (mem_we) begin
                                r_age_vld[r_pipe_idx] <= 1'b1;
                            end
                        end else begin
                            r_pick <= pick_nx;
                            if (better) begin
                                r_best <= age_q;
                            end
                        end
                    end
                    if (scan_last) begin
                        if (r_op == OP_ALLOC) begin
                            // Steal the oldest: mark it free and restart its age
                            r_free[pick_nx]    <= 1'b1;
                            r_age_vld[pick_nx] <= 1'b0;
                        end
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (load_out) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_res_status;
                        r_out_chan   <= CHOSEN_W'(r_pick);
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tdata  = {3'b000, r_out_chan};

    `VCA_ASSERT_NEXT(a_pick_cleared, i_clk, i_rst_n, load_out && (r_res_status == ST_ALLOCATED), r_free[r_pick] && !r_age_vld[r_pick], "allocated channel not free with cleared age")
    `VCA_ASSERT_NOW(a_pipe_in_run, i_clk, i_rst_n, r_pipe_vld, r_state == S_RUN, "scan data pending outside walk")
    `VCA_ASSERT_NOW(a_cnt_range, i_clk, i_rst_n, r_state == S_RUN, r_cnt <= CW'(NUM_CHANNELS), "walk counter past channel count")

endmodule

`default_nettype wire
